// ----- hdl/csem_pkg.sv -----
`timescale 1ns / 1ps

package csem_pkg;

    localparam int DEF_NUM_SEMAPHORES = 64;
    localparam int DEF_WAIT_DEPTH     = 8;
    localparam int DEF_TASK_ID_BITS   = 8;

    localparam int HANDLE_W = 6;
    localparam int COUNT_W  = 16;
    localparam int TASK_W   = 8;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        ACT_CREATE  = 2'd0,
        ACT_DESTROY = 2'd1,
        ACT_DOWN    = 2'd2,
        ACT_UP      = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BLOCKED    = 3'd1,
        ST_BAD_HANDLE = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_QUEUE_FULL = 3'd4,
        ST_RELEASED   = 3'd5,
        ST_OVERFLOW   = 3'd6
    } status_t;

    typedef struct packed {
        status_t                     status;
        logic                        wr_slot;
        logic                        valid_next;
        logic                        push;
        logic                        pop;
        logic signed [COUNT_W-1:0]   count_next;
    } alu_res_t;

endpackage

// ----- hdl/csem_ram.sv -----
`timescale 1ns / 1ps

module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/csem_alu.sv -----
`timescale 1ns / 1ps

module csem_alu (
    input  csem_pkg::act_t                          action,
    input  logic                                    valid,
    input  logic signed [csem_pkg::COUNT_W-1:0]     count,
    input  logic                                    q_full,
    input  logic                                    q_nonempty,
    output csem_pkg::alu_res_t                      res
);
    import csem_pkg::*;

    logic signed [COUNT_W:0] delta;
    logic signed [COUNT_W:0] sum;

    // one shared adder: +1 for up, -1 otherwise
    assign delta = (action == ACT_UP) ? 17'sd1 : -17'sd1;
    assign sum   = {count[COUNT_W-1], count} + delta;

    always_comb
    begin
        res            = '0;
        res.status     = ST_OK;
        res.valid_next = 1'b1;
        res.count_next = sum[COUNT_W-1:0];
        if (!valid)
        begin
            res.status = ST_BAD_HANDLE;
        end
        else
        begin
            unique case (action)
                ACT_DESTROY:
                begin
                    res.wr_slot    = 1'b1;
                    res.valid_next = 1'b0;
                    res.count_next = count;
                end
                ACT_DOWN:
                begin
                    if (count > 16'sd0)
                    begin
                        res.wr_slot = 1'b1;
                    end
                    else if (count == COUNT_MIN || q_full)
                    begin
                        res.status = ST_QUEUE_FULL;
                    end
                    else
                    begin
                        res.wr_slot = 1'b1;
                        res.push    = 1'b1;
                        res.status  = ST_BLOCKED;
                    end
                end
                ACT_UP:
                begin
                    if (count == COUNT_MAX)
                    begin
                        res.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        res.wr_slot = 1'b1;
                        // still at or below zero after the increment
                        res.pop     = (count < 16'sd0) && q_nonempty;
                    end
                end
                ACT_CREATE:
                begin
                    res.count_next = count;
                end
            endcase
        end
    end

endmodule

// ----- hdl/counting_semaphore_table_top.sv -----
// down, an up that wakes nobody and a bad slot: slot read in S_LOOK, result in S_OUT
// up that wakes a waiter: S_LOOK, S_WREAD, S_OUT; create: S_SCAN up to the lowest free slot
// or over every slot when full; destroy with waiters: S_LOOK, then S_WREAD, S_OUT per waiter
// throughput: one input at a time, next input taken the cycle after the last result beat
// reset: asynchronous, active low; then a clearing pass over every slot of
// the slot memory during which no input is taken
`timescale 1ns / 1ps

module counting_semaphore_table_top #(
    parameter int NUM_SEMAPHORES = csem_pkg::DEF_NUM_SEMAPHORES,
    parameter int WAIT_DEPTH     = csem_pkg::DEF_WAIT_DEPTH,
    parameter int TASK_ID_BITS   = csem_pkg::DEF_TASK_ID_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // handle[5:0], initial_count[21:6], task_id[29:22]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_handle[5:0], woken_task[13:6]
    output logic [3:0]  m_tuser,   // status[2:0], woken_valid[3]
    output logic        m_tlast
);
    import csem_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SEMAPHORES);
    localparam int HW     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FW     = $clog2(WAIT_DEPTH + 1);
    localparam int SW     = 1 + COUNT_W + HW + FW;
    localparam int TW     = TASK_ID_BITS;
    localparam int WDEPTH = NUM_SEMAPHORES << HW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LOOK,
        S_WREAD,
        S_OUT
    } state_t;

    state_t                     state_reg, state_next;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    act_t                       act_reg, act_next;
    logic [HANDLE_W-1:0]        handle_reg, handle_next;
    logic signed [COUNT_W-1:0]  init_reg, init_next;
    logic [TW-1:0]              task_reg, task_next;
    logic [HW-1:0]              q_head_reg, q_head_next;
    logic [FW-1:0]              q_fill_reg, q_fill_next;
    logic                       draining_reg, draining_next;
    status_t                    st_reg, st_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    status_t                    o_status_reg, o_status_next;
    logic [HANDLE_W-1:0]        o_handle_reg, o_handle_next;
    logic                       o_wv_reg, o_wv_next;
    logic [TASK_W-1:0]          o_wt_reg, o_wt_next;
    logic                       o_last_reg, o_last_next;

    // slot memory: valid, counter, queue head, queue fill
    logic                       sl_we;
    logic [SLOT_W-1:0]          sl_raddr;
    logic [SW-1:0]              sl_wdata;
    logic [SW-1:0]              sl_rdata;

    logic                       rd_valid;
    logic signed [COUNT_W-1:0]  rd_count;
    logic [HW-1:0]              rd_head;
    logic [FW-1:0]              rd_fill;

    logic                       wt_we;
    logic [SLOT_W+HW-1:0]       wt_waddr;
    logic [SLOT_W+HW-1:0]       wt_raddr;
    logic [TW-1:0]              wt_rdata;

    logic [FW:0]                tail_sum;
    logic [HW-1:0]              tail;
    logic [HW-1:0]              head_inc;
    logic [HW-1:0]              head_new;
    logic [FW-1:0]              fill_new;
    logic                       s_fire;
    logic                       m_fire;
    logic                       handle_ok;

    alu_res_t                   res;

    function automatic logic [HW-1:0] wrap_inc(input logic [HW-1:0] h);
        logic [HW-1:0] r;
        if (h == HW'(WAIT_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = h + 1'b1;
        end
        return r;
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid_reg && m_tready;
    assign handle_ok = (32'(s_tdata[5:0]) < NUM_SEMAPHORES);

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, o_wt_reg, o_handle_reg};
    assign m_tuser   = {o_wv_reg, o_status_reg};
    assign m_tlast   = o_last_reg;

    assign rd_valid = sl_rdata[SW-1];
    assign rd_count = sl_rdata[SW-2 -: COUNT_W];
    assign rd_head  = sl_rdata[FW +: HW];
    assign rd_fill  = sl_rdata[FW-1:0];

    csem_alu u_alu (
        .action     (act_reg),
        .valid      (rd_valid),
        .count      (rd_count),
        .q_full     (rd_fill >= FW'(WAIT_DEPTH)),
        .q_nonempty (rd_fill != '0),
        .res        (res)
    );

    // free position behind the last waiter, fill is below the depth here
    assign tail_sum = (FW+1)'(rd_head) + (FW+1)'(rd_fill);
    assign tail     = (tail_sum >= (FW+1)'(WAIT_DEPTH))
                      ? HW'(tail_sum - (FW+1)'(WAIT_DEPTH)) : HW'(tail_sum);
    assign head_inc = wrap_inc(rd_head);

    always_comb
    begin
        head_new = rd_head;
        fill_new = rd_fill;
        if (act_reg == ACT_DESTROY)
        begin
            head_new = '0;
            fill_new = '0;
        end
        else if (res.push)
        begin
            fill_new = rd_fill + 1'b1;
        end
        else if (res.pop)
        begin
            head_new = head_inc;
            fill_new = rd_fill - 1'b1;
        end
    end

    always_comb
    begin
        sl_we    = 1'b0;
        sl_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                sl_we = 1'b1;
            end
            S_SCAN:
            begin
                sl_we    = !rd_valid;
                sl_wdata = {1'b1, init_reg, HW'(0), FW'(0)};
            end
            S_LOOK:
            begin
                sl_we    = res.wr_slot;
                sl_wdata = {res.valid_next, res.count_next, head_new, fill_new};
            end
            default:
            begin
                sl_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            sl_raddr = (act_t'(s_tuser) == ACT_CREATE) ? '0 : SLOT_W'(s_tdata[5:0]);
        end
        else
        begin
            sl_raddr = slot_reg + 1'b1;
        end
    end

    assign wt_we    = (state_reg == S_LOOK) && res.push;
    assign wt_waddr = {slot_reg, tail};
    assign wt_raddr = {slot_reg, (state_reg == S_LOOK) ? rd_head : q_head_reg};

    csem_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_SEMAPHORES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (slot_reg),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    csem_ram #(
        .WIDTH (TW),
        .DEPTH (WDEPTH)
    ) u_wait_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (task_reg),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        act_next      = act_reg;
        handle_next   = handle_reg;
        init_next     = init_reg;
        task_next     = task_reg;
        q_head_next   = q_head_reg;
        q_fill_next   = q_fill_reg;
        draining_next = draining_reg;
        st_next       = st_reg;
        m_tvalid_next = m_tvalid_reg;
        o_status_next = o_status_reg;
        o_handle_next = o_handle_reg;
        o_wv_next     = o_wv_reg;
        o_wt_next     = o_wt_reg;
        o_last_next   = o_last_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_W'(NUM_SEMAPHORES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_fire)
                begin
                    act_next    = act_t'(s_tuser);
                    handle_next = s_tdata[5:0];
                    init_next   = s_tdata[21:6];
                    task_next   = TW'(s_tdata[29:22]);
                    o_wv_next   = 1'b0;
                    o_wt_next   = '0;
                    o_last_next = 1'b1;
                    if (act_t'(s_tuser) == ACT_CREATE)
                    begin
                        slot_next  = '0;
                        state_next = S_SCAN;
                    end
                    else if (!handle_ok)
                    begin
                        o_status_next = ST_BAD_HANDLE;
                        o_handle_next = s_tdata[5:0];
                        m_tvalid_next = 1'b1;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        slot_next  = SLOT_W'(s_tdata[5:0]);
                        state_next = S_LOOK;
                    end
                end
            end
            S_SCAN:
            begin
                if (!rd_valid)
                begin
                    o_status_next = ST_OK;
                    o_handle_next = HANDLE_W'(slot_reg);
                    m_tvalid_next = 1'b1;
                    state_next    = S_OUT;
                end
                else if (slot_reg == SLOT_W'(NUM_SEMAPHORES - 1))
                begin
                    o_status_next = ST_TABLE_FULL;
                    o_handle_next = '0;
                    m_tvalid_next = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_LOOK:
            begin
                o_handle_next = handle_reg;
                st_next       = res.status;
                if (rd_valid && act_reg == ACT_DESTROY && rd_fill != '0)
                begin
                    q_head_next   = rd_head;
                    q_fill_next   = rd_fill;
                    draining_next = 1'b1;
                    st_next       = ST_RELEASED;
                    state_next    = S_WREAD;
                end
                else if (res.pop)
                begin
                    draining_next = 1'b0;
                    state_next    = S_WREAD;
                end
                else
                begin
                    o_status_next = res.status;
                    m_tvalid_next = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_WREAD:
            begin
                o_status_next = st_reg;
                o_wv_next     = 1'b1;
                o_wt_next     = TASK_W'(wt_rdata);
                o_last_next   = draining_reg ? (q_fill_reg == FW'(1)) : 1'b1;
                q_head_next   = wrap_inc(q_head_reg);
                q_fill_next   = q_fill_reg - 1'b1;
                m_tvalid_next = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (m_fire)
                begin
                    m_tvalid_next = 1'b0;
                    if (draining_reg && q_fill_reg != '0)
                    begin
                        state_next = S_WREAD;
                    end
                    else
                    begin
                        draining_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            slot_reg     <= '0;
            act_reg      <= ACT_CREATE;
            handle_reg   <= '0;
            init_reg     <= '0;
            task_reg     <= '0;
            q_head_reg   <= '0;
            q_fill_reg   <= '0;
            draining_reg <= 1'b0;
            st_reg       <= ST_OK;
            m_tvalid_reg <= 1'b0;
            o_status_reg <= ST_OK;
            o_handle_reg <= '0;
            o_wv_reg     <= 1'b0;
            o_wt_reg     <= '0;
            o_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            act_reg      <= act_next;
            handle_reg   <= handle_next;
            init_reg     <= init_next;
            task_reg     <= task_next;
            q_head_reg   <= q_head_next;
            q_fill_reg   <= q_fill_next;
            draining_reg <= draining_next;
            st_reg       <= st_next;
            m_tvalid_reg <= m_tvalid_next;
            o_status_reg <= o_status_next;
            o_handle_reg <= o_handle_next;
            o_wv_reg     <= o_wv_next;
            o_wt_reg     <= o_wt_next;
            o_last_reg   <= o_last_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a new input is only taken once every result beat has left
    a_idle_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid_reg)
        else $error("input taken while a result is pending");

    // only destroy spreads over several result beats
    a_multi_only_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !o_last_reg |-> o_status_reg == ST_RELEASED)
        else $error("non-final beat that is not a release");

    // every released waiter names a task
    a_release_has_task: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && o_status_reg == ST_RELEASED |-> o_wv_reg)
        else $error("release beat without a woken task");

    // a blocked result always comes with a queue write
    a_blocked_pushed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) && o_status_reg == ST_BLOCKED |-> $past(wt_we))
        else $error("blocked without a waiter write");
`endif

endmodule

// ----- verif/csem_checker.sv -----
`timescale 1ns / 1ps

module csem_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // handle[5:0], initial_count[21:6], task_id[29:22]
    input  logic [1:0]  s_tuser,   // action[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // out_handle[5:0], woken_task[13:6]
    input  logic [3:0]  m_tuser,   // status[2:0], woken_valid[3]
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding
);
    import csem_pkg::*;

    localparam int SLOTS = 64;
    localparam int DEPTH = 8;

    typedef struct {
        status_t        status;
        logic [5:0]     handle;
        logic           woken_valid;
        logic [7:0]     woken_task;
        logic           last;
    } sem_result_t;

    // shadow of the semaphore table
    logic       slot_live  [SLOTS];
    int         sem_count  [SLOTS];
    logic [7:0] wait_fifo  [SLOTS][DEPTH];
    int         fifo_head  [SLOTS];
    int         fifo_fill  [SLOTS];

    sem_result_t due_results[$];

    task automatic queue_result(input status_t st, input logic [5:0] h, input logic wv,
                                input logic [7:0] wt, input logic lst);
        sem_result_t r;
        r.status      = st;
        r.handle      = h;
        r.woken_valid = wv;
        r.woken_task  = wt;
        r.last        = lst;
        due_results.push_back(r);
    endtask

    task automatic apply_sem_op(input act_t act, input logic [5:0] h,
                                input logic signed [15:0] init, input logic [7:0] tid);
        int         free_slot;
        int         c;
        logic [7:0] t;
        free_slot = -1;
        if (act == ACT_CREATE)
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!slot_live[i])
                    free_slot = i;
            if (free_slot < 0)
            begin
                queue_result(ST_TABLE_FULL, 6'd0, 1'b0, 8'd0, 1'b1);
            end
            else
            begin
                slot_live[free_slot] = 1'b1;
                sem_count[free_slot] = int'(init);
                fifo_head[free_slot] = 0;
                fifo_fill[free_slot] = 0;
                queue_result(ST_OK, free_slot[5:0], 1'b0, 8'd0, 1'b1);
            end
        end
        else if (!slot_live[h])
        begin
            queue_result(ST_BAD_HANDLE, h, 1'b0, 8'd0, 1'b1);
        end
        else if (act == ACT_DESTROY)
        begin
            slot_live[h] = 1'b0;
            if (fifo_fill[h] == 0)
                queue_result(ST_OK, h, 1'b0, 8'd0, 1'b1);
            // every waiter is let go, oldest first
            while (fifo_fill[h] > 0)
            begin
                t = wait_fifo[h][fifo_head[h]];
                fifo_head[h] = (fifo_head[h] + 1) % DEPTH;
                fifo_fill[h]--;
                queue_result(ST_RELEASED, h, 1'b1, t, fifo_fill[h] == 0);
            end
            fifo_head[h] = 0;
        end
        else if (act == ACT_DOWN)
        begin
            c = sem_count[h];
            if (c - 1 >= 0)
            begin
                sem_count[h] = c - 1;
                queue_result(ST_OK, h, 1'b0, 8'd0, 1'b1);
            end
            else if (c <= -32768 || fifo_fill[h] >= DEPTH)
            begin
                queue_result(ST_QUEUE_FULL, h, 1'b0, 8'd0, 1'b1);
            end
            else
            begin
                sem_count[h] = c - 1;
                wait_fifo[h][(fifo_head[h] + fifo_fill[h]) % DEPTH] = tid;
                fifo_fill[h]++;
                queue_result(ST_BLOCKED, h, 1'b0, 8'd0, 1'b1);
            end
        end
        else
        begin
            if (sem_count[h] >= 32767)
            begin
                queue_result(ST_OVERFLOW, h, 1'b0, 8'd0, 1'b1);
            end
            else
            begin
                sem_count[h]++;
                if (sem_count[h] <= 0 && fifo_fill[h] > 0)
                begin
                    t = wait_fifo[h][fifo_head[h]];
                    fifo_head[h] = (fifo_head[h] + 1) % DEPTH;
                    fifo_fill[h]--;
                    queue_result(ST_OK, h, 1'b1, t, 1'b1);
                end
                else
                begin
                    queue_result(ST_OK, h, 1'b0, 8'd0, 1'b1);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sem_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_live[i] = 1'b0;
                sem_count[i] = 0;
                fifo_head[i] = 0;
                fifo_fill[i] = 0;
            end
            due_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // results first: none can belong to an input taken at the same edge
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing due: status %0d handle %0d",
                           m_tuser[2:0], m_tdata[5:0]);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tuser[2:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser[2:0]);
                        mismatches++;
                    end
                    if (m_tdata[5:0] !== want.handle)
                    begin
                        $error("out_handle: expected %0d, got %0d", want.handle, m_tdata[5:0]);
                        mismatches++;
                    end
                    if (m_tuser[3] !== want.woken_valid)
                    begin
                        $error("woken_valid: expected %0d, got %0d", want.woken_valid,
                               m_tuser[3]);
                        mismatches++;
                    end
                    if (m_tdata[13:6] !== want.woken_task)
                    begin
                        $error("woken_task: expected %0d, got %0d", want.woken_task,
                               m_tdata[13:6]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_sem_op(act_t'(s_tuser), s_tdata[5:0], $signed(s_tdata[21:6]),
                             s_tdata[29:22]);
            outstanding = due_results.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import csem_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // handle[5:0], initial_count[21:6], task_id[29:22]
    logic [1:0]  s_tuser = '0;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // out_handle[5:0], woken_task[13:6]
    logic [3:0]  m_tuser;        // status[2:0], woken_valid[3]
    logic        m_tlast;

    int mismatches;
    int outstanding;

    // stimulus side bookkeeping of which slots hold a semaphore
    logic in_use [64];
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;

    always #2 clk = ~clk;

    counting_semaphore_table_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    csem_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_beat(input act_t act, input logic [5:0] h,
                             input logic signed [15:0] cnt, input logic [7:0] tid);
        int free_slot;
        free_slot = -1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, tid, cnt, h};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (act == ACT_CREATE)
        begin
            for (int i = 63; i >= 0; i--)
                if (!in_use[i])
                    free_slot = i;
            if (free_slot >= 0)
                in_use[free_slot] = 1'b1;
        end
        else if (act == ACT_DESTROY)
        begin
            in_use[h] = 1'b0;
        end
    endtask

    // first let the checker book the beat just taken, then wait until nothing is due
    task automatic drain_pause;
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("counting_semaphore_table_top: mismatch");
        $finish;
    end

    initial
    begin
        int                 r;
        int                 live_cnt;
        int                 pick;
        act_t               act;
        logic [5:0]         h;
        logic signed [15:0] cnt;
        for (int i = 0; i < 64; i++)
            in_use[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: counter extremes, queue wrap and overflow, destroy cases
        send_beat(ACT_CREATE, 6'd0, COUNT_MAX, 8'd0);
        send_beat(ACT_UP, 6'd0, 16'sd0, 8'd0);
        send_beat(ACT_CREATE, 6'd0, COUNT_MIN, 8'd0);
        send_beat(ACT_DOWN, 6'd1, 16'sd0, 8'h5A);
        send_beat(ACT_UP, 6'd1, 16'sd0, 8'd0);
        send_beat(ACT_CREATE, 6'd0, 16'sd0, 8'd0);
        send_beat(ACT_DOWN, 6'd2, 16'sd0, 8'hFF);
        send_beat(ACT_DOWN, 6'd2, 16'sd0, 8'h00);
        send_beat(ACT_UP, 6'd2, 16'sd0, 8'd0);
        for (int k = 0; k < 7; k++)
            send_beat(ACT_DOWN, 6'd2, 16'sd0, 8'(8'h11 * (k + 1)));
        send_beat(ACT_DOWN, 6'd2, 16'sd0, 8'hAA);
        send_beat(ACT_DESTROY, 6'd2, 16'sd0, 8'd0);
        send_beat(ACT_DESTROY, 6'd2, 16'sd0, 8'd0);
        send_beat(ACT_DESTROY, 6'd0, 16'sd0, 8'd0);
        send_beat(ACT_DOWN, 6'd0, 16'sd0, 8'd0);
        send_beat(ACT_CREATE, 6'd63, 16'sd1, 8'hFF);
        send_beat(ACT_DOWN, 6'd0, 16'sd0, 8'd0);
        send_beat(ACT_UP, 6'd63, -16'sd1, 8'hFF);
        send_beat(ACT_DESTROY, 6'd1, 16'sd0, 8'd0);
        drain_pause();

        for (int n = 0; n < 410; n++)
        begin
            if (n == 350)
                calm = 1'b1;
            if (n == 100)
                hold_req = 1'b1;
            if (n == 220)
                drain_pause();

            // early: churn a few slots, middle: fill the table, late: tear down
            r = $urandom_range(0, 99);
            if (n < 150)
                act = r < 15 ? ACT_CREATE : r < 23 ? ACT_DESTROY : r < 68 ? ACT_DOWN : ACT_UP;
            else if (n < 250)
                act = r < 55 ? ACT_CREATE : r < 60 ? ACT_DESTROY : r < 85 ? ACT_DOWN : ACT_UP;
            else
                act = r < 12 ? ACT_CREATE : r < 37 ? ACT_DESTROY : r < 72 ? ACT_DOWN : ACT_UP;

            live_cnt = 0;
            for (int i = 0; i < 64; i++)
                if (in_use[i])
                    live_cnt++;
            h = 6'($urandom_range(0, 63));
            if (live_cnt > 0 && $urandom_range(0, 9) < 9)
            begin
                pick = $urandom_range(0, live_cnt - 1);
                for (int i = 0; i < 64; i++)
                    if (in_use[i])
                    begin
                        if (pick == 0)
                            h = 6'(i);
                        pick--;
                    end
            end

            r = $urandom_range(0, 9);
            if (r < 6)
                cnt = 16'($signed($urandom_range(0, 6)) - 3);
            else if (r < 8)
            begin
                case ($urandom_range(0, 3))
                    0: cnt = COUNT_MAX;
                    1: cnt = COUNT_MIN;
                    2: cnt = COUNT_MAX - 16'sd1;
                    default: cnt = COUNT_MIN + 16'sd1;
                endcase
            end
            else
                cnt = 16'($urandom_range(0, 65535));

            send_beat(act, h, cnt, 8'($urandom_range(0, 255)));

            if (!calm && $urandom_range(0, 4) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("counting_semaphore_table_top: match");
        else
            $display("counting_semaphore_table_top: mismatch");
        $finish;
    end

endmodule

// ----- counting_semaphore_table_top.f -----
hdl/csem_pkg.sv
hdl/csem_ram.sv
hdl/csem_alu.sv
hdl/counting_semaphore_table_top.sv
verif/csem_checker.sv
verif/tb.sv
